/* design/matrix_multiply_4x4_macros.svh */
// Assertion macros for the matrix_multiply_4x4 design.
// Needs a clock named clk and a synchronous reset named rst in the including scope.
`ifndef MATRIX_MULTIPLY_4X4_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_MACROS_SVH

// Check that a property holds on every clock edge outside reset
`define MM4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define MM4_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* design/mm4_pkg.sv */
// Shared types and constants for the matrix_multiply_4x4 design.
// No dependencies; used by the controller, datapath and top level.
package mm4_pkg;

  localparam int DIM_DEF   = 4;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int FRAC_BITS = 16;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_left;
    logic wr_right;
    logic rd_en;
    logic first;
    logic last_term;
    logic last_elem;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic res_load;
  } stat_t;

endpackage

/* design/mm4_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mm4_ctrl.sv */
// Controller: loads both matrices, then sequences the dot product terms.
// Depends on mm4_pkg and matrix_multiply_4x4_macros.svh.
`include "matrix_multiply_4x4_macros.svh"

module mm4_ctrl #(
  parameter int DIM = mm4_pkg::DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           element_valid,
  output logic                           element_ready,
  input  mm4_pkg::stat_t                 stat,
  output mm4_pkg::cmd_t                  cmd,
  output logic [$clog2(DIM*DIM)-1:0]     waddr,
  output logic [$clog2(DIM*DIM)-1:0]     raddr_a,
  output logic [$clog2(DIM*DIM)-1:0]     raddr_b
);

  import mm4_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int CW    = $clog2(CELLS);
  localparam int LW    = $clog2(2 * CELLS);
  localparam int DW    = $clog2(DIM);

  state_t         state, state_next;
  logic [LW-1:0]  load_count, load_count_next;
  logic [DW-1:0]  row, row_next;
  logic [DW-1:0]  col, col_next;
  logic [DW-1:0]  k, k_next;
  logic           last_cell;
  logic           load_fire;

  assign last_cell = (row == DW'(DIM - 1)) && (col == DW'(DIM - 1));
  assign load_fire = element_valid && element_ready;

  // Store addresses: row-major for A, column walk for B
  assign raddr_a = CW'(CW'(row) * CW'(DIM) + CW'(k));
  assign raddr_b = CW'(CW'(k) * CW'(DIM) + CW'(col));
  assign waddr   = (load_count < LW'(CELLS)) ? load_count[CW-1:0]
                                              : CW'(load_count - LW'(CELLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      k          <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      row        <= row_next;
      col        <= col_next;
      k          <= k_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    row_next        = row;
    col_next        = col;
    k_next          = k;
    element_ready   = 1'b0;
    cmd             = '0;
    case (state)
      ST_LOAD: begin
        element_ready = 1'b1;
        if (load_fire) begin
          cmd.wr_left  = (load_count < LW'(CELLS));
          cmd.wr_right = (load_count >= LW'(CELLS));
          if (load_count == LW'(2 * CELLS - 1)) begin
            load_count_next = '0;
            row_next        = '0;
            col_next        = '0;
            k_next          = '0;
            state_next      = ST_ISSUE;
          end else begin
            load_count_next = load_count + LW'(1);
          end
        end
      end
      ST_ISSUE: begin
        // Start a new cell only once the output register can take it
        if ((k != '0) || stat.out_free) begin
          cmd.rd_en     = 1'b1;
          cmd.first     = (k == '0);
          cmd.last_term = (k == DW'(DIM - 1));
          cmd.last_elem = last_cell;
          if (k == DW'(DIM - 1)) begin
            k_next     = '0;
            state_next = ST_WAIT;
          end else begin
            k_next = k + DW'(1);
          end
        end
      end
      ST_WAIT: begin
        // Advance to the next cell once this one has reached the output
        if (stat.res_load) begin
          if (last_cell) begin
            row_next   = '0;
            col_next   = '0;
            state_next = ST_LOAD;
          end else begin
            if (col == DW'(DIM - 1)) begin
              col_next = '0;
              row_next = row + DW'(1);
            end else begin
              col_next = col + DW'(1);
            end
            state_next = ST_ISSUE;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  `MM4_ASSERT(a_no_read_while_loading, !(cmd.rd_en && element_ready), "read issued during load")
  `MM4_ASSERT(a_first_term_needs_space, !(cmd.rd_en && cmd.first) || stat.out_free, "cell started with output register busy")
  `MM4_ASSERT_NEXT(a_full_load_starts_issue, load_fire && (load_count == LW'(2 * CELLS - 1)), state == ST_ISSUE, "no issue after final element")

endmodule

/* design/mm4_datapath.sv */
// Datapath: both element stores, multiply, accumulate, shift, saturate, output register.
// Depends on mm4_pkg, mm4_ram and matrix_multiply_4x4_macros.svh.
`include "matrix_multiply_4x4_macros.svh"

module mm4_datapath #(
  parameter int DIM = mm4_pkg::DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [mm4_pkg::DATA_W-1:0]     element,
  input  mm4_pkg::cmd_t                  cmd,
  input  logic [$clog2(DIM*DIM)-1:0]     waddr,
  input  logic [$clog2(DIM*DIM)-1:0]     raddr_a,
  input  logic [$clog2(DIM*DIM)-1:0]     raddr_b,
  output mm4_pkg::stat_t                 stat,
  output logic [mm4_pkg::DATA_W-1:0]     product,
  output logic                           last,
  output logic                           product_valid,
  input  logic                           product_ready
);

  import mm4_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int ACC_W = PROD_W + $clog2(DIM);

  logic [DATA_W-1:0]        a_data, b_data;
  cmd_t                     s1, s2, s3;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, acc_next, shifted;
  logic [ACC_W-1:0]         prod_ext;
  logic [ACC_W-DATA_W:0]    upper;
  logic [DATA_W-1:0]        sat;

  mm4_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_left (
    .clk   (clk),
    .we    (cmd.wr_left),
    .waddr (waddr),
    .wdata (element),
    .raddr (raddr_a),
    .rdata (a_data)
  );

  mm4_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_right (
    .clk   (clk),
    .we    (cmd.wr_right),
    .waddr (waddr),
    .wdata (element),
    .raddr (raddr_b),
    .rdata (b_data)
  );

  // Carry the term tags alongside the store reads, product and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
    end else begin
      s1 <= cmd;
      s2 <= s1;
      s3 <= s2;
    end
  end

  // Multiply one term, then accumulate it
  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign acc_next = s2.first ? signed'(prod_ext) : acc + signed'(prod_ext);

  always_ff @(posedge clk) begin
    if (s1.rd_en) begin
      prod <= signed'(a_data) * signed'(b_data);
    end
    if (s2.rd_en) begin
      acc <= acc_next;
    end
  end

  // Drop the fraction bits and clamp to the element range
  assign shifted = acc >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:DATA_W-1];
  always_comb begin
    if ((&upper) || !(|upper)) begin
      sat = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat = SAT_MIN;
    end else begin
      sat = SAT_MAX;
    end
  end

  assign stat.res_load = s3.rd_en && s3.last_term;
  assign stat.out_free = !product_valid || product_ready;

  // Output register: load on a finished cell, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      product_valid <= 1'b0;
    end else if (stat.res_load) begin
      product_valid <= 1'b1;
    end else if (product_ready) begin
      product_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_load) begin
      product <= sat;
      last    <= s3.last_elem;
    end
  end

  `MM4_ASSERT(a_no_overwrite, !stat.res_load || stat.out_free, "result overwrote a waiting item")
  `MM4_ASSERT(a_terms_contiguous, !(s2.rd_en && !s2.first) || s3.rd_en, "accumulation chain broken")
  `MM4_ASSERT_NEXT(a_result_shown, stat.res_load, product_valid, "finished cell not presented")

endmodule

/* design/matrix_multiply_4x4.sv */
// Load: 2*DIM*DIM elements are taken, all of A and then all of B, each in row-major order.
// Compute: each cell issues one store read per term; the multiply, sum and clamp stages drain
//   before the next cell starts, and a cell starts only once the output register can take it.
//   A new A, B pair is taken only after the last product has loaded the output register.
// Reset: synchronous rst clears the controller, the term tags and the output valid; stores are not cleared.
// Top level: joins the controller and the datapath. Depends on mm4_pkg, mm4_ctrl, mm4_datapath.
module matrix_multiply_4x4 #(
  parameter int DIM = mm4_pkg::DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mm4_pkg::DATA_W-1:0] element,
  input  logic                       element_valid,
  output logic                       element_ready,
  output logic [mm4_pkg::DATA_W-1:0] product,
  output logic                       last,
  output logic                       product_valid,
  input  logic                       product_ready
);

  import mm4_pkg::*;

  localparam int CW = $clog2(DIM * DIM);

  cmd_t          cmd;
  stat_t         stat;
  logic [CW-1:0] waddr, raddr_a, raddr_b;

  mm4_ctrl #(.DIM(DIM)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .element_valid (element_valid),
    .element_ready (element_ready),
    .stat          (stat),
    .cmd           (cmd),
    .waddr         (waddr),
    .raddr_a       (raddr_a),
    .raddr_b       (raddr_b)
  );

  mm4_datapath #(.DIM(DIM)) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .element       (element),
    .cmd           (cmd),
    .waddr         (waddr),
    .raddr_a       (raddr_a),
    .raddr_b       (raddr_b),
    .stat          (stat),
    .product       (product),
    .last          (last),
    .product_valid (product_valid),
    .product_ready (product_ready)
  );

endmodule

/* dv/tb_matrix_multiply_4x4.sv */
`timescale 1ns / 1ps
// Self-checking bench for matrix_multiply_4x4: streams A then B elements in, predicts
// every Q16.16 product element in-bench and checks the product stream in order.
// Depends on mm4_pkg and the matrix_multiply_4x4 RTL.
module tb_matrix_multiply_4x4;
  import mm4_pkg::*;

  localparam int MAT_DIM      = DIM_DEF;
  localparam int CELLS        = MAT_DIM * MAT_DIM;
  localparam int LONG_STALL   = 400;
  localparam int DRAIN_CYCLES = 8 * (MAT_DIM + 4);
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic signed [127:0] SUM_TOP    = 128'sd2147483647;
  localparam logic signed [127:0] SUM_BOTTOM = -128'sd2147483648;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              is_last;
  } product_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [DATA_W-1:0] element = '0;
  logic              element_valid = 1'b0;
  logic              element_ready;
  logic [DATA_W-1:0] product;
  logic              last;
  logic              product_valid;
  logic              product_ready = 1'b0;

  // Elements waiting to be sent, and product elements waiting to arrive
  logic [DATA_W-1:0] pending_elements [$];
  product_t          products_due [$];

  // Predictor copy of the two stores and the load position
  logic signed [DATA_W-1:0] left_mat [CELLS];
  logic signed [DATA_W-1:0] right_mat [CELLS];
  int                       load_count = 0;

  int       send_gap_pct = 0;
  int       recv_gap_pct = 0;
  bit       long_stall_go = 1'b0;
  bit       long_stall_done = 1'b0;
  int       long_stall_left = 0;
  int       mismatches = 0;
  int       products_checked = 0;
  int       cycle_count = 0;
  product_t product_want;

  // Corner values: saturation both ways, rounding toward minus infinity, zero sums
  logic [DATA_W-1:0] extreme_set [2 * CELLS] = '{
    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
    32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000,
    32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0001_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000
  };

  matrix_multiply_4x4 #(
    .DIM(MAT_DIM)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .element      (element),
    .element_valid(element_valid),
    .element_ready(element_ready),
    .product      (product),
    .last         (last),
    .product_valid(product_valid),
    .product_ready(product_ready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Row of A times column of B: exact sum, arithmetic shift, clamp to 32 bits
  function automatic logic [DATA_W-1:0] q16_dot_cell(int row, int col);
    logic signed [127:0]      acc;
    logic signed [PROD_W-1:0] term;
    int                       k;
    acc = '0;
    for (k = 0; k < MAT_DIM; k++) begin
      term = left_mat[row * MAT_DIM + k] * right_mat[k * MAT_DIM + col];
      acc += term;
    end
    acc = acc >>> FRAC_BITS;
    if (acc > SUM_TOP) return SAT_MAX;
    if (acc < SUM_BOTTOM) return SAT_MIN;
    return acc[DATA_W-1:0];
  endfunction

  // Mix of full-range, small and moderate Q16.16 values and corner values
  function automatic logic [DATA_W-1:0] pick_element();
    logic [DATA_W-1:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 3))
      0: return raw;
      1: return {{12{raw[19]}}, raw[19:0]};
      2: return {{8{raw[23]}}, raw[23:0]};
      default: begin
        case ($urandom_range(0, 4))
          0: return SAT_MAX;
          1: return SAT_MIN;
          2: return '0;
          3: return '1;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  task automatic queue_random_pair();
    int i;
    for (i = 0; i < 2 * CELLS; i++) pending_elements.push_back(pick_element());
  endtask

  // Hold off until every element is taken and every product has come back
  task automatic wait_quiet();
    while (pending_elements.size() != 0 || element_valid || products_due.size() != 0)
      @(negedge clk);
  endtask

  // Drive elements; fold each accepted item into the predictor
  always @(posedge clk) begin
    if (rst) begin
      element_valid <= 1'b0;
    end else begin
      if (element_valid && element_ready) begin
        if (load_count < CELLS) left_mat[load_count] = element;
        else right_mat[load_count - CELLS] = element;
        load_count++;
        if (load_count == 2 * CELLS) begin
          for (int r = 0; r < MAT_DIM; r++) begin
            for (int c = 0; c < MAT_DIM; c++) begin
              products_due.push_back(product_t'{q16_dot_cell(r, c),
                                                (r == MAT_DIM - 1) && (c == MAT_DIM - 1)});
            end
          end
          load_count = 0;
        end
      end
      // Offer the next item only once the current one has gone
      if (!element_valid || element_ready) begin
        if (pending_elements.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          element       <= pending_elements.pop_front();
          element_valid <= 1'b1;
        end else begin
          element_valid <= 1'b0;
        end
      end
    end
  end

  // Check each accepted product item against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      product_ready <= 1'b0;
    end else begin
      if (product_valid && product_ready) begin
        if (products_due.size() == 0) begin
          $display("%0t: unexpected product: expected none, got %h last %b",
                   $time, product, last);
          mismatches++;
        end else begin
          product_want = products_due.pop_front();
          if (product !== product_want.value) begin
            $display("%0t: product item %0d value: expected %h, got %h",
                     $time, products_checked, product_want.value, product);
            mismatches++;
          end
          if (last !== product_want.is_last) begin
            $display("%0t: product item %0d last: expected %b, got %b",
                     $time, products_checked, product_want.is_last, last);
            mismatches++;
          end
        end
        products_checked++;
      end
      // Long hold-off once, then random stalls
      if (long_stall_go && !long_stall_done) begin
        long_stall_done <= 1'b1;
        long_stall_left <= LONG_STALL;
        product_ready   <= 1'b0;
      end else if (long_stall_left != 0) begin
        long_stall_left <= long_stall_left - 1;
        product_ready   <= 1'b0;
      end else begin
        product_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Sparse sender, heavily stalled receiver: corner matrices then a random pair
    @(negedge clk);
    send_gap_pct = 35;
    recv_gap_pct = 79;
    foreach (extreme_set[i]) pending_elements.push_back(extreme_set[i]);
    queue_random_pair();
    wait_quiet();

    // Swap the idling: identity A checks ordering against a random B
    send_gap_pct = 79;
    recv_gap_pct = 35;
    for (int i = 0; i < CELLS; i++)
      pending_elements.push_back((i / MAT_DIM == i % MAT_DIM) ? 32'h0001_0000 : 32'h0);
    for (int i = 0; i < CELLS; i++) pending_elements.push_back($urandom);
    wait_quiet();

    // No idling, with one long receiver hold-off so the input backs up
    send_gap_pct  = 0;
    recv_gap_pct  = 0;
    long_stall_go = 1'b1;
    queue_random_pair();
    queue_random_pair();
    wait_quiet();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && products_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
